// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AST_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cpt_pkg.sv =====
// Types and constants of the card permission table.
package cpt_pkg;

  localparam int OP_W         = 3;
  localparam int SLOT_FIELD_W = 7;
  localparam int ID_FIELD_W   = 32;
  localparam int PERM_W       = 2;
  localparam int CODE_FIELD_W = 32;
  localparam int LEN_W        = 4;
  localparam int OCC_W        = 8;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_VERIFY = 3'd3;
  localparam logic [OP_W-1:0] OP_CODEP  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  // How an accepted word is processed.
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_READ,
    KIND_SCAN
  } kind_e;

  typedef struct packed {
    logic accept;
    logic rd;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scan_end;
    logic  out_free;
  } sts_t;

endpackage

// ===== hw/rtl/cpt_if.sv =====
// Channel interfaces of the card permission table.
interface cpt_req_if import cpt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic                    auto_slot;
  logic [SLOT_FIELD_W-1:0] slot;
  logic [ID_FIELD_W-1:0]   card_id;
  logic [PERM_W-1:0]       perm_bits;
  logic [CODE_FIELD_W-1:0] access_code;
  logic [LEN_W-1:0]        code_length;

  modport source (output valid, op, auto_slot, slot, card_id, perm_bits, access_code,
                  code_length, input ready);
  modport sink (input valid, op, auto_slot, slot, card_id, perm_bits, access_code,
                code_length, output ready);
endinterface

interface cpt_rsp_if import cpt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic [SLOT_FIELD_W-1:0] result_slot;
  logic [PERM_W-1:0]       result_perm;
  logic [OCC_W-1:0]        occupied;

  modport source (output valid, ok, result_slot, result_perm, occupied, input ready);
  modport sink (input valid, ok, result_slot, result_perm, occupied, output ready);
endinterface

interface cpt_cfg_if import cpt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CODE_FIELD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/cpt_ram.sv =====
// Generic single-clock RAM, one write and one registered read port.
module cpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cpt_ctrl.sv =====
// Sequencer of the card permission table.
module cpt_ctrl import cpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.kind)
            KIND_READ: state_d = ST_READ;
            KIND_SCAN: state_d = ST_SCAN;
            default:   state_d = ST_FIN;
          endcase
        end
      end
      ST_READ: state_d = ST_FIN;
      ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == ST_IDLE);
    end
  end

  always_comb begin
    cmd_o.accept = rdy_q && in_valid_i;
    cmd_o.rd     = (state_q == ST_READ);
    cmd_o.scan   = (state_q == ST_SCAN);
    cmd_o.commit = (state_q == ST_FIN) && sts_i.out_free;
  end

  assign in_ready_o = rdy_q;

endmodule

// ===== hw/rtl/cpt_dp.sv =====
// Datapath of the card permission table: slot memory, count, scan and result.
module cpt_dp import cpt_pkg::*; #(
  parameter int SLOTS     = 128,
  parameter int ID_BITS   = 32,
  parameter int CODE_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    cfg_valid_i,
  input  logic [CODE_FIELD_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]         op_i,
  input  logic                    auto_slot_i,
  input  logic [SLOT_FIELD_W-1:0] slot_i,
  input  logic [ID_FIELD_W-1:0]   card_id_i,
  input  logic [PERM_W-1:0]       perm_bits_i,
  input  logic [CODE_FIELD_W-1:0] access_code_i,
  input  logic [LEN_W-1:0]        code_length_i,
  input  logic                    rsp_ready_i,
  output logic                    rsp_valid_o,
  output logic                    ok_o,
  output logic [SLOT_FIELD_W-1:0] result_slot_o,
  output logic [PERM_W-1:0]       result_perm_o,
  output logic [OCC_W-1:0]        occupied_o
);

  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ROW_W      = PERM_W + ID_BITS + CODE_BITS;
  localparam int CODE_BYTES = (CODE_BITS + 7) / 8;

  // Latched word.
  logic [OP_W-1:0]         op_q;
  logic                    auto_q;
  logic [SLOT_FIELD_W-1:0] slot_q;
  logic [ID_BITS-1:0]      id_q;
  logic [PERM_W-1:0]       perm_q;
  logic [CODE_BITS-1:0]    code_q;
  logic                    len_ok_q;

  logic [CODE_BITS-1:0] init_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SLOTS-1:0]     vld_q;

  logic [SLOT_W:0]      scan_idx_q;
  logic                 cmp_vld_q;
  logic [SLOT_W-1:0]    cmp_idx_q;
  logic                 hit_q;
  logic [SLOT_W-1:0]    hit_idx_q;
  logic [PERM_W-1:0]    hit_perm_q;

  logic                    rsp_valid_q;
  logic                    ok_q;
  logic [SLOT_FIELD_W-1:0] rslot_q;
  logic [PERM_W-1:0]       rperm_q;
  logic [OCC_W-1:0]        occ_q;

  logic [ID_BITS-1:0]   in_id;
  logic [CODE_BITS-1:0] in_code;
  logic                 in_len_ok;
  logic                 full;

  kind_e                acc_kind;
  logic                 scan_end;
  logic                 out_free;

  logic                 ram_re;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [ROW_W-1:0]     rdata;
  logic [PERM_W-1:0]    rd_perm;
  logic [ID_BITS-1:0]   rd_id;
  logic [CODE_BITS-1:0] rd_code;

  logic                 issue;
  logic [PERM_W-1:0]    scan_perm;
  logic                 scan_match;
  logic                 hit_now;

  logic [SLOT_W-1:0]    slot_idx;
  logic                 in_range;
  logic [PERM_W-1:0]    cur_perm;
  logic                 pre_ok;

  logic                 c_ok;
  logic [SLOT_W-1:0]    c_rslot;
  logic [PERM_W-1:0]    c_rperm;
  logic                 c_we;
  logic [SLOT_W-1:0]    c_waddr;
  logic [ROW_W-1:0]     c_wdata;
  logic                 c_inc;
  logic                 c_dec;
  logic                 c_clr;
  logic                 ram_we;

  assign in_id     = ID_BITS'(card_id_i);
  assign in_code   = CODE_BITS'(access_code_i);
  assign in_len_ok = (code_length_i == LEN_W'(CODE_BYTES));
  assign full      = (cnt_q >= CNT_W'(SLOTS));

  // Decide at acceptance how the word is processed.
  always_comb begin
    acc_kind = KIND_DIRECT;
    unique case (op_i) inside
      OP_ADD: begin
        if (perm_bits_i != '0 && !full) begin
          acc_kind = auto_slot_i ? KIND_SCAN : KIND_READ;
        end
      end
      OP_SET, OP_VERIFY, OP_READ: acc_kind = KIND_READ;
      OP_SEARCH: begin
        if (cnt_q != '0) begin
          acc_kind = KIND_SCAN;
        end
      end
      OP_CODEP: begin
        if (in_len_ok && in_code != init_q) begin
          acc_kind = KIND_SCAN;
        end
      end
      default: acc_kind = KIND_DIRECT;
    endcase
  end

  // Slot memory: each row is {perm, id, code}.
  assign issue     = cmd_i.scan && (scan_idx_q < (SLOT_W + 1)'(SLOTS));
  assign ram_re    = cmd_i.rd || issue;
  assign ram_raddr = cmd_i.scan ? scan_idx_q[SLOT_W-1:0] : slot_idx;
  assign ram_we    = cmd_i.commit && c_we;

  cpt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign rd_perm = rdata[ROW_W-1 -: PERM_W];
  assign rd_id   = rdata[CODE_BITS +: ID_BITS];
  assign rd_code = rdata[CODE_BITS-1:0];

  // A row never written since reset or clear counts as a free slot.
  assign scan_perm = vld_q[cmp_idx_q] ? rd_perm : '0;

  always_comb begin
    case (op_q)
      OP_ADD:    scan_match = (scan_perm == '0);
      OP_SEARCH: scan_match = (scan_perm != '0) && (rd_id == id_q);
      OP_CODEP:  scan_match = (scan_perm != '0) && (rd_code == code_q);
      default:   scan_match = 1'b0;
    endcase
  end

  assign hit_now  = cmd_i.scan && cmp_vld_q && scan_match;
  assign scan_end = cmp_vld_q && (scan_match || cmp_idx_q == SLOT_W'(SLOTS - 1));
  assign out_free = !rsp_valid_q || rsp_ready_i;

  assign sts_o = '{kind: acc_kind, scan_end: scan_end, out_free: out_free};

  assign slot_idx = SLOT_W'(slot_q);
  assign in_range = (32'(slot_q) < 32'(SLOTS));
  assign cur_perm = vld_q[slot_idx] ? rd_perm : '0;
  assign pre_ok   = (perm_q != '0) && !full;

  always_comb begin
    c_ok    = 1'b0;
    c_rslot = '0;
    c_rperm = '0;
    c_we    = 1'b0;
    c_waddr = slot_idx;
    c_wdata = {perm_q, id_q, init_q};
    c_inc   = 1'b0;
    c_dec   = 1'b0;
    c_clr   = 1'b0;
    unique case (op_q)
      OP_ADD: begin
        if (auto_q) begin
          if (hit_q) begin
            c_ok    = 1'b1;
            c_rslot = hit_idx_q;
            c_we    = 1'b1;
            c_waddr = hit_idx_q;
            c_inc   = 1'b1;
          end
        end else if (pre_ok && in_range && (cur_perm == '0 || rd_id == id_q)) begin
          c_ok    = 1'b1;
          c_rslot = slot_idx;
          c_we    = 1'b1;
          if (cur_perm == '0) begin
            c_inc = 1'b1;
          end else begin
            c_wdata = {cur_perm | perm_q, rd_id, rd_code};
          end
        end
      end
      OP_SET: begin
        if (in_range && cur_perm != '0) begin
          c_ok    = 1'b1;
          c_we    = 1'b1;
          c_wdata = {perm_q, (perm_q == '0) ? '0 : rd_id, rd_code};
          c_dec   = (perm_q == '0);
        end
      end
      OP_SEARCH: begin
        if (hit_q) begin
          c_ok    = 1'b1;
          c_rslot = hit_idx_q;
        end
      end
      OP_VERIFY: begin
        if (len_ok_q && in_range && rd_code == code_q) begin
          c_rperm = cur_perm;
          c_ok    = (cur_perm != '0);
        end
      end
      OP_CODEP: begin
        if (hit_q) begin
          c_ok    = 1'b1;
          c_rperm = hit_perm_q;
        end
      end
      OP_READ: begin
        if (in_range) begin
          c_rperm = cur_perm;
          c_ok    = (cur_perm != '0);
        end
      end
      OP_CLEAR: begin
        c_ok  = 1'b1;
        c_clr = 1'b1;
      end
      default: c_ok = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (c_clr) begin
      cnt_d = '0;
    end else if (c_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (c_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  // Word, scan index, hit index and perm, and result data registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_i;
      auto_q   <= auto_slot_i;
      slot_q   <= slot_i;
      id_q     <= in_id;
      perm_q   <= perm_bits_i;
      code_q   <= in_code;
      len_ok_q <= in_len_ok;
    end
    if (hit_now) begin
      hit_idx_q  <= cmp_idx_q;
      hit_perm_q <= scan_perm;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= scan_idx_q[SLOT_W-1:0];
    end
    if (cmd_i.accept) begin
      scan_idx_q <= '0;
    end else if (issue) begin
      scan_idx_q <= scan_idx_q + (SLOT_W + 1)'(1);
    end
    if (cmd_i.commit) begin
      ok_q    <= c_ok;
      rslot_q <= SLOT_FIELD_W'(c_rslot);
      rperm_q <= c_rperm;
      occ_q   <= OCC_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      cnt_q       <= '0;
      vld_q       <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        init_q <= CODE_BITS'(cfg_data_i);
      end
      if (cmd_i.commit) begin
        cnt_q <= cnt_d;
        if (c_clr) begin
          vld_q <= '0;
        end else if (c_we) begin
          vld_q[c_waddr] <= 1'b1;
        end
      end
      if (cmd_i.accept) begin
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= issue;
        if (hit_now) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o   = rsp_valid_q;
  assign ok_o          = ok_q;
  assign result_slot_o = rslot_q;
  assign result_perm_o = rperm_q;
  assign occupied_o    = occ_q;

endmodule

// ===== hw/rtl/card_permission_table.sv =====
// Card permission table: SLOTS slots, each with a card ID, an access code and two permission
// bits, plus a count of occupied slots. One request word is processed at a time. Requests that
// touch a single slot (add to a chosen slot, set permission, verify code, read permission) go
// through a read state and then a commit state, because the slot memory has a registered read;
// add and set write the row back. Clear and requests rejected up front go straight to commit.
// Searches (add to the first free slot, search by ID, search by code) walk the slot memory one
// row per cycle through its single read port and stop at the first match, then commit. A new
// request is taken once the previous result sits in the output register; the table then waits
// only if that result is still not taken when the next one is ready. The initial-code register
// is written on its own channel and must be written only while the table is idle. No clearing
// pass follows reset.
module card_permission_table import cpt_pkg::*; #(
  parameter int SLOTS     = 128,
  parameter int ID_BITS   = 32,
  parameter int CODE_BITS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  cpt_cfg_if.sink    cfg_i,
  cpt_req_if.sink    req_i,
  cpt_rsp_if.source  rsp_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  cpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpt_dp #(
    .SLOTS     (SLOTS),
    .ID_BITS   (ID_BITS),
    .CODE_BITS (CODE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .op_i          (req_i.op),
    .auto_slot_i   (req_i.auto_slot),
    .slot_i        (req_i.slot),
    .card_id_i     (req_i.card_id),
    .perm_bits_i   (req_i.perm_bits),
    .access_code_i (req_i.access_code),
    .code_length_i (req_i.code_length),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .ok_o          (rsp_o.ok),
    .result_slot_o (rsp_o.result_slot),
    .result_perm_o (rsp_o.result_perm),
    .occupied_o    (rsp_o.occupied)
  );

endmodule

// ===== hw/rtl/cpt_checker.sv =====
// Port-level checks of the card permission table and their binding.
`include "assert_macros.svh"

module cpt_checker #(
  parameter int SLOTS = 128
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [6:0] rsp_slot_i,
  input logic [7:0] rsp_occupied_i
);

  logic req_acc;

  assign req_acc = req_valid_i && req_ready_i;

  // A result word stays offered until it is taken.
  `AST_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result dropped")
  // Only one request is in work at a time.
  `AST_NEXT(a_one_req, clk_i, rst_ni, req_acc, !req_ready_i, "request taken while busy")
  // The count of occupied slots never exceeds the table size.
  `AST_SAME(a_occ_range, clk_i, rst_ni, rsp_valid_i, 32'(rsp_occupied_i) <= 32'(SLOTS), "count too big")
  // A reported slot is always a slot of the table.
  `AST_SAME(a_slot_range, clk_i, rst_ni, rsp_valid_i, 32'(rsp_slot_i) < 32'(SLOTS), "slot too big")

endmodule

bind card_permission_table cpt_checker #(
  .SLOTS (SLOTS)
) u_cpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_slot_i     (rsp_o.result_slot),
  .rsp_occupied_i (rsp_o.occupied)
);
